>>> rtl/hsv_pkg.sv
// ----------------------------------------------------------------------------
// hsv_pkg
// Shared types and constants of the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsv_pkg;

   // Fixed point of saturation and value: ONE = 1 << FRAC_BITS (legal 8..16)
   localparam int FRAC_BITS = 12;
   localparam int ONE       = 1 << FRAC_BITS;

   // Width of the input fields and of the color channels
   localparam int IN_W   = 13;
   localparam int CHAN_W = 8;

   // Internal value width: holds ONE and every input bit pattern
   localparam int VAL_W = (FRAC_BITS + 1 > IN_W) ? FRAC_BITS + 1 : IN_W;

   // Hue in 1/16 degree: full turn, one sector, and 960 = 15 << 6
   localparam logic [IN_W-1:0] HUE_FULL   = IN_W'(5760);
   localparam logic [IN_W-1:0] HUE_SECTOR = IN_W'(960);
   localparam int              WT_W       = 10;
   localparam int              DIV_SHIFT  = 6;
   localparam int              DIV_ODD    = 15;

   // Divide by 15 through a reciprocal: q * K >> QW, K = floor(2^QW / 15)
   localparam int QW     = VAL_W + 4;
   localparam int KW     = QW - 3;
   localparam int RECIP  = (1 << QW) / DIV_ODD;
   localparam int PROD_W = QW + KW;

   typedef struct packed {
      logic [IN_W-1:0] hue;
      logic [IN_W-1:0] saturation;
      logic [IN_W-1:0] brightness;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              range_error;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_MUL_C = 5'b00010,
      ST_MUL_X = 5'b00100,
      ST_MUL_Q = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   typedef enum logic [2:0] {
      SEC_RED_YELLOW    = 3'd0,
      SEC_YELLOW_GREEN  = 3'd1,
      SEC_GREEN_CYAN    = 3'd2,
      SEC_CYAN_BLUE     = 3'd3,
      SEC_BLUE_MAGENTA  = 3'd4,
      SEC_MAGENTA_RED   = 3'd5
   } sector_type;

endpackage

>>> rtl/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Fixed-point HSV to 8-bit RGB conversion with one shared multiplier.
//
// Each item carries a hue in 1/16 degree (0..5760, where 5760 wraps to 0) and
// a saturation and value in Q12 (4096 = 1.0). The block returns one item per
// input: the held RGB color and a range_error flag. An out-of-range input sets
// the flag and leaves the held color untouched. A legal item passes through the
// states MUL_C, MUL_X, MUL_Q and DONE: the single multiplier forms V*S, then
// C*w, then the reciprocal product that divides by 960; a last step corrects
// the quotient, adds M and scales by 255 with a shift and subtract. An
// out-of-range item skips the multiplier steps and goes straight to DONE.
// The input is taken only while the sequencer is idle; a finished result
// sits in an output register and waits there for rsp_ready, holding the
// sequencer in its last step until taken, which stretches the item by the
// stall.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  hsv_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output hsv_pkg::rsp_type rsp_data
);

   localparam int VW = hsv_pkg::VAL_W;
   localparam int FB = hsv_pkg::FRAC_BITS;
   localparam int CW = hsv_pkg::CHAN_W;

   // Sequencer and item registers
   hsv_pkg::state_type   state_ff, state_in;
   hsv_pkg::sector_type  sector_ff, sector_in;
   logic [hsv_pkg::WT_W-1:0] wt_ff, wt_in;
   logic [VW-1:0]        val_ff, sat_ff;
   logic                 err_ff;
   logic [VW-1:0]        c_ff;
   logic [hsv_pkg::QW-1:0] q_ff;
   logic [hsv_pkg::PROD_W-1:0] prod_ff, prod_in;

   // Held color and result register
   logic [CW-1:0]        held_red_ff, held_green_ff, held_blue_ff;
   logic                 rsp_valid_ff;
   hsv_pkg::rsp_type     rsp_data_ff;

   logic                 req_take;
   logic                 req_err;
   logic                 rsp_free;
   logic [hsv_pkg::IN_W-1:0] hue_wrap;
   logic [hsv_pkg::IN_W-1:0] sec_base;
   logic [hsv_pkg::IN_W-1:0] hue_ofs;

   logic [hsv_pkg::QW-1:0] mul_a;
   logic [hsv_pkg::KW-1:0] mul_b;

   logic [VW-1:0]        est;
   logic [hsv_pkg::QW-1:0] rem;
   logic [VW-1:0]        x_val;
   logic [VW-1:0]        m_val;
   logic [VW-1:0]        r_comp, g_comp, b_comp;
   logic [CW-1:0]        red_new, green_new, blue_new;

   function automatic logic [CW-1:0] scale255(input logic [VW-1:0] y);
      logic [VW+CW-1:0] prod;
      prod = ({y, CW'(0)} - (VW+CW)'(y));
      return prod[FB +: CW];
   endfunction

   assign req_ready = (state_ff == hsv_pkg::ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Range check and sector split of the incoming hue
   assign req_err = (int'(req_data.hue) > int'(hsv_pkg::HUE_FULL))
                 || (int'(req_data.saturation) > hsv_pkg::ONE)
                 || (int'(req_data.brightness) > hsv_pkg::ONE);
   assign hue_wrap = (req_data.hue == hsv_pkg::HUE_FULL) ? '0 : req_data.hue;

   always_comb begin
      case (hue_wrap) inside
         [hsv_pkg::IN_W'(0) : hsv_pkg::HUE_SECTOR - 1'b1]: begin
            sector_in = hsv_pkg::SEC_RED_YELLOW;
            sec_base  = '0;
         end
         [hsv_pkg::HUE_SECTOR : hsv_pkg::IN_W'(2) * hsv_pkg::HUE_SECTOR - 1'b1]: begin
            sector_in = hsv_pkg::SEC_YELLOW_GREEN;
            sec_base  = hsv_pkg::HUE_SECTOR;
         end
         [hsv_pkg::IN_W'(2) * hsv_pkg::HUE_SECTOR :
          hsv_pkg::IN_W'(3) * hsv_pkg::HUE_SECTOR - 1'b1]: begin
            sector_in = hsv_pkg::SEC_GREEN_CYAN;
            sec_base  = hsv_pkg::IN_W'(2) * hsv_pkg::HUE_SECTOR;
         end
         [hsv_pkg::IN_W'(3) * hsv_pkg::HUE_SECTOR :
          hsv_pkg::IN_W'(4) * hsv_pkg::HUE_SECTOR - 1'b1]: begin
            sector_in = hsv_pkg::SEC_CYAN_BLUE;
            sec_base  = hsv_pkg::IN_W'(3) * hsv_pkg::HUE_SECTOR;
         end
         [hsv_pkg::IN_W'(4) * hsv_pkg::HUE_SECTOR :
          hsv_pkg::IN_W'(5) * hsv_pkg::HUE_SECTOR - 1'b1]: begin
            sector_in = hsv_pkg::SEC_BLUE_MAGENTA;
            sec_base  = hsv_pkg::IN_W'(4) * hsv_pkg::HUE_SECTOR;
         end
         default: begin
            sector_in = hsv_pkg::SEC_MAGENTA_RED;
            sec_base  = hsv_pkg::IN_W'(5) * hsv_pkg::HUE_SECTOR;
         end
      endcase
   end

   // Rising sectors weight by the offset, falling sectors by its complement
   assign hue_ofs = hue_wrap - sec_base;
   assign wt_in   = sector_in[0] ? hsv_pkg::WT_W'(hsv_pkg::HUE_SECTOR - hue_ofs)
                                 : hsv_pkg::WT_W'(hue_ofs);

   // Shared multiplier operand select
   always_comb begin
      case (state_ff)
         hsv_pkg::ST_MUL_C: begin
            mul_a = hsv_pkg::QW'(val_ff);
            mul_b = hsv_pkg::KW'(sat_ff);
         end
         hsv_pkg::ST_MUL_X: begin
            mul_a = hsv_pkg::QW'(prod_ff[FB +: VW]);
            mul_b = hsv_pkg::KW'(wt_ff);
         end
         hsv_pkg::ST_MUL_Q: begin
            mul_a = prod_ff[hsv_pkg::DIV_SHIFT +: hsv_pkg::QW];
            mul_b = hsv_pkg::KW'(hsv_pkg::RECIP);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign prod_in = hsv_pkg::PROD_W'(mul_a) * hsv_pkg::PROD_W'(mul_b);

   // Final step: correct the reciprocal quotient by one, add M, scale
   assign est   = prod_ff[hsv_pkg::QW +: VW];
   assign rem   = q_ff - ({est, 4'b0000} - hsv_pkg::QW'(est));
   assign x_val = est + VW'(rem >= hsv_pkg::QW'(hsv_pkg::DIV_ODD));
   assign m_val = val_ff - c_ff;

   always_comb begin
      r_comp = '0;
      g_comp = '0;
      b_comp = '0;
      case (sector_ff)
         hsv_pkg::SEC_RED_YELLOW: begin
            r_comp = c_ff;
            g_comp = x_val;
         end
         hsv_pkg::SEC_YELLOW_GREEN: begin
            r_comp = x_val;
            g_comp = c_ff;
         end
         hsv_pkg::SEC_GREEN_CYAN: begin
            g_comp = c_ff;
            b_comp = x_val;
         end
         hsv_pkg::SEC_CYAN_BLUE: begin
            g_comp = x_val;
            b_comp = c_ff;
         end
         hsv_pkg::SEC_BLUE_MAGENTA: begin
            r_comp = x_val;
            b_comp = c_ff;
         end
         default: begin
            r_comp = c_ff;
            b_comp = x_val;
         end
      endcase
   end

   assign red_new   = scale255(r_comp + m_val);
   assign green_new = scale255(g_comp + m_val);
   assign blue_new  = scale255(b_comp + m_val);

   // Sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hsv_pkg::ST_IDLE: begin
            if (req_take) begin
               state_in = req_err ? hsv_pkg::ST_DONE : hsv_pkg::ST_MUL_C;
            end
         end
         hsv_pkg::ST_MUL_C: state_in = hsv_pkg::ST_MUL_X;
         hsv_pkg::ST_MUL_X: state_in = hsv_pkg::ST_MUL_Q;
         hsv_pkg::ST_MUL_Q: state_in = hsv_pkg::ST_DONE;
         hsv_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = hsv_pkg::ST_IDLE;
            end
         end
         default: state_in = hsv_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= hsv_pkg::ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         held_red_ff   <= '0;
         held_green_ff <= '0;
         held_blue_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == hsv_pkg::ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
            if (!err_ff) begin
               held_red_ff   <= red_new;
               held_green_ff <= green_new;
               held_blue_ff  <= blue_new;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers: capture the item, step the datapath, load the result
   always_ff @(posedge clock) begin
      // hold the quotient product while the finished item waits
      if (state_ff != hsv_pkg::ST_DONE) begin
         prod_ff <= prod_in;
      end
      if (req_take) begin
         val_ff    <= VW'(req_data.brightness);
         sat_ff    <= VW'(req_data.saturation);
         err_ff    <= req_err;
         sector_ff <= sector_in;
         wt_ff     <= wt_in;
      end
      if (state_ff == hsv_pkg::ST_MUL_X) begin
         c_ff <= prod_ff[FB +: VW];
      end
      if (state_ff == hsv_pkg::ST_MUL_Q) begin
         q_ff <= prod_ff[hsv_pkg::DIV_SHIFT +: hsv_pkg::QW];
      end
      if (state_ff == hsv_pkg::ST_DONE && rsp_free) begin
         rsp_data_ff.red         <= err_ff ? held_red_ff   : red_new;
         rsp_data_ff.green       <= err_ff ? held_green_ff : green_new;
         rsp_data_ff.blue        <= err_ff ? held_blue_ff  : blue_new;
         rsp_data_ff.range_error <= err_ff;
      end
   end

   // Finishing step always leaves a result in the output register
   a_done_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == hsv_pkg::ST_DONE && rsp_free |=> rsp_valid_ff)
      else $error("finished item did not reach the output register");

   // Held color moves only when a legal item finishes
   a_held_only_done: assert property (@(posedge clock) disable iff (reset)
      !(state_ff == hsv_pkg::ST_DONE && !err_ff)
      |=> $stable({held_red_ff, held_green_ff, held_blue_ff}))
      else $error("held color changed outside a legal finish");

   // Reciprocal estimate is never more than one short of the true quotient
   a_recip_close: assert property (@(posedge clock) disable iff (reset)
      state_ff == hsv_pkg::ST_DONE && !err_ff
      |-> rem < hsv_pkg::QW'(2 * hsv_pkg::DIV_ODD))
      else $error("divide-by-960 correction out of range");

   // Secondary component never exceeds chroma
   a_x_le_c: assert property (@(posedge clock) disable iff (reset)
      state_ff == hsv_pkg::ST_DONE && !err_ff |-> x_val <= c_ff)
      else $error("secondary component exceeds chroma");

endmodule
